FILE: hw/rtl/locr8_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// locr8_pkg
// Shared types and constants of the layer compositor: fix15 constants,
// the accumulated pixel that travels from the compositor to the output
// converter, and the state encodings of both sides.
// ----------------------------------------------------------------------------
package locr8_pkg;

  localparam logic [15:0] UNITY_FX   = 16'd32768;
  localparam logic [15:0] FIX15_HALF = 16'd16384;
  localparam logic [7:0]  MAX8       = 8'd255;
  localparam logic [15:0] MAX16      = 16'hFFFF;

  // Quotient bits kept by the un-premultiply divider; anything larger
  // saturates the byte anyway.
  localparam int unsigned QBITS = 17;
  localparam int unsigned CNT_W = $clog2(QBITS);
  localparam int unsigned NCHAN = 3;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
  } pix_t;

  typedef enum logic {
    F_IDLE,
    F_BLEND
  } f_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } b_state_e;

endpackage
`default_nettype wire

FILE: hw/rtl/layer_over_composite_to_rgb8.sv
`default_nettype none
// ----------------------------------------------------------------------------
// layer_over_composite_to_rgb8
// Per-pixel over compositing of premultiplied fix15 layers, 8-bit output.
//
// Usage: feed the layers of one pixel bottom first on the input channel
// (valid_i / stall_o); first_layer_i loads the accumulator, later items are
// blended over it with their opacity, and last_layer_i sends the pixel to
// the output channel (valid_o / stall_i) as un-premultiplied 8-bit RGBA.
// A first layer loads the accumulator when it is accepted; every other
// layer is accepted and then followed by a blend state that updates the
// accumulator while the input stalls. A pixel conversion in the back end
// pops the pixel, runs 17 divider steps, then scales and hands off; the
// queue lets the compositor run ahead by QUEUE_DEPTH pixels. An item that
// is first and last is pushed when accepted, a blended last layer from its
// blend state; valid_o rises once the back end, when free, has converted it.
// Reset clears the accumulator to zero, empties the queue and drops any
// pending result. While stall_i is high the result holds in the output
// register; the back end finishes its next pixel and waits, and the front
// stalls once the queue fills.
// ----------------------------------------------------------------------------
module layer_over_composite_to_rgb8 #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [15:0] red_i,
  input  wire logic [15:0] green_i,
  input  wire logic [15:0] blue_i,
  input  wire logic [15:0] alpha_i,
  input  wire logic [15:0] opacity_i,
  input  wire logic        first_layer_i,
  input  wire logic        last_layer_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [7:0]       red_out_o,
  output logic [7:0]       green_out_o,
  output logic [7:0]       blue_out_o,
  output logic [7:0]       alpha_out_o
);
  import locr8_pkg::*;

  // accumulated pixels between front and back
  logic push, pop, q_full, q_empty;
  pix_t push_pix, pop_pix;

  // front: accept layers, blend into the accumulator
  locr8_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_i),
    .stall_o       (stall_o),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .alpha_i       (alpha_i),
    .opacity_i     (opacity_i),
    .first_layer_i (first_layer_i),
    .last_layer_i  (last_layer_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_pix_o    (push_pix)
  );

  // short queue decoupling blend from conversion
  locr8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_pix_i (push_pix),
    .pop_i      (pop),
    .pop_pix_o  (pop_pix),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  // back: un-premultiply, scale to 8 bits, output register
  locr8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .pix_i       (pop_pix),
    .pop_o       (pop),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .alpha_out_o (alpha_out_o)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/locr8_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// locr8_front
// Accepts layer items and runs the premultiplied over blend into the
// accumulator; pushes the accumulated pixel on the last layer.
// ----------------------------------------------------------------------------
module locr8_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    stall_o,
  input  wire logic [15:0]        red_i,
  input  wire logic [15:0]        green_i,
  input  wire logic [15:0]        blue_i,
  input  wire logic [15:0]        alpha_i,
  input  wire logic [15:0]        opacity_i,
  input  wire logic               first_layer_i,
  input  wire logic               last_layer_i,
  input  wire logic               q_full_i,
  output logic                    push_o,
  output locr8_pkg::pix_t         push_pix_o
);
  import locr8_pkg::*;

  f_state_e state_q, state_d;
  pix_t     acc_q, acc_d;
  logic [31:0] topop_q [NCHAN];
  logic [31:0] ao_q;
  logic        last_q;
  logic        accept;

  logic [15:0] top_in [NCHAN];
  logic [15:0] acc_c  [NCHAN];
  logic [15:0] blend  [NCHAN];
  logic [15:0] p, minus;
  logic [32:0] sum    [NCHAN];
  logic [31:0] aprod;
  logic [17:0] na;

  assign accept    = valid_i && !stall_o;
  assign top_in[0] = red_i;
  assign top_in[1] = green_i;
  assign top_in[2] = blue_i;
  assign acc_c[0]  = acc_q.red;
  assign acc_c[1]  = acc_q.green;
  assign acc_c[2]  = acc_q.blue;

  // blend math, from the products registered at accept
  always_comb begin
    p     = (ao_q[31:15] > {1'b0, UNITY_FX}) ? UNITY_FX : ao_q[30:15];
    minus = UNITY_FX - p;
    for (int i = 0; i < NCHAN; i++) begin
      sum[i]   = {1'b0, topop_q[i]} + 33'({16'd0, acc_c[i]} * {16'd0, minus});
      blend[i] = (sum[i][32:15] > {2'b00, MAX16}) ? MAX16 : sum[i][30:15];
    end
    aprod = {16'd0, acc_q.alpha} * {16'd0, minus};
    na    = {2'b00, p} + {1'b0, aprod[31:15]};
  end

  always_comb begin
    acc_d = acc_q;
    if (accept && first_layer_i) begin
      acc_d = '{red: red_i, green: green_i, blue: blue_i, alpha: alpha_i};
    end else if (state_q == F_BLEND) begin
      acc_d.red   = blend[0];
      acc_d.green = blend[1];
      acc_d.blue  = blend[2];
      acc_d.alpha = (na > {2'b00, UNITY_FX}) ? UNITY_FX : na[15:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept && !first_layer_i) state_d = F_BLEND;
      end
      F_BLEND: state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    stall_o = 1'b1;
    push_o  = 1'b0;
    case (state_q)
      F_IDLE: begin
        stall_o = q_full_i;
        push_o  = accept && first_layer_i && last_layer_i;
      end
      F_BLEND: begin
        stall_o = 1'b1;
        push_o  = last_q;
      end
      default: begin
        stall_o = 1'b1;
        push_o  = 1'b0;
      end
    endcase
  end

  assign push_pix_o = acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      last_q <= last_layer_i;
      ao_q   <= 32'(alpha_i) * 32'(opacity_i);
      for (int i = 0; i < NCHAN; i++) begin
        topop_q[i] <= 32'(top_in[i]) * 32'(opacity_i);
      end
    end
  end

`ifndef SYNTHESIS
  a_blend_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !first_layer_i) |=> (state_q == F_BLEND && stall_o))
    else $error("blend cycle missing after accepted layer");
  a_blend_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_BLEND) |=> (state_q == F_IDLE))
    else $error("blend lasted more than one cycle");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/locr8_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// locr8_queue
// Short FIFO of accumulated pixels between compositor and converter.
// ----------------------------------------------------------------------------
module locr8_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire locr8_pkg::pix_t push_pix_i,
  input  wire logic            pop_i,
  output locr8_pkg::pix_t      pop_pix_o,
  output logic                 full_o,
  output logic                 empty_o
);
  import locr8_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W_Q = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]   LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W_Q-1:0] FULL_CNT = CNT_W_Q'(DEPTH);

  pix_t mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W_Q-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == FULL_CNT);
  assign empty_o   = (cnt_q == '0);
  assign pop_pix_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
    if (pop_i)  rd_d = (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_pix_i;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("pixel pushed into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pixel popped from empty queue");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/locr8_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// locr8_back
// Un-premultiplies a queued pixel with three bit-serial dividers, scales
// to 8 bits and holds the result in the output register.
// ----------------------------------------------------------------------------
module locr8_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            empty_i,
  input  wire locr8_pkg::pix_t pix_i,
  output logic                 pop_o,
  output logic                 valid_o,
  input  wire logic            stall_i,
  output logic [7:0]           red_out_o,
  output logic [7:0]           green_out_o,
  output logic [7:0]           blue_out_o,
  output logic [7:0]           alpha_out_o
);
  import locr8_pkg::*;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QBITS - 1);

  b_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]      den_q;
  logic [15:0]      rem_q [NCHAN];
  logic [QBITS-1:0] nq_q  [NCHAN];
  logic             sat_q [NCHAN];
  logic             out_valid_q;
  logic [7:0]       byte_q [NCHAN];
  logic [7:0]       alpha_out_q;

  logic        load, step, emit;
  logic [15:0] chan  [NCHAN];
  logic [30:0] num   [NCHAN];
  logic [16:0] trial [NCHAN];
  logic        ge    [NCHAN];
  logic [25:0] scaled [NCHAN];
  logic [7:0]  byte_c [NCHAN];
  logic [23:0] amul;

  assign chan[0] = pix_i.red;
  assign chan[1] = pix_i.green;
  assign chan[2] = pix_i.blue;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (!empty_i) state_d = B_DIV;
      B_DIV:  if (cnt_q == LAST_STEP) state_d = B_DONE;
      B_DONE: if (!out_valid_q || !stall_i) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    load = 1'b0;
    step = 1'b0;
    emit = 1'b0;
    case (state_q)
      B_IDLE: load = !empty_i;
      B_DIV:  step = 1'b1;
      B_DONE: emit = !out_valid_q || !stall_i;
      default: begin
        load = 1'b0;
        step = 1'b0;
        emit = 1'b0;
      end
    endcase
  end

  assign pop_o = load;
  assign cnt_d = load ? '0 : (step ? cnt_q + 1'b1 : cnt_q);

  always_comb begin
    for (int i = 0; i < NCHAN; i++) begin
      num[i]   = {chan[i], 15'd0} + {16'd0, pix_i.alpha[15:1]};
      trial[i] = {rem_q[i], nq_q[i][QBITS-1]};
      ge[i]    = (trial[i] >= {1'b0, den_q});
      scaled[i] = 26'(nq_q[i]) * 26'(MAX8) + 26'(FIX15_HALF);
      if (den_q == '0) byte_c[i] = '0;
      else if (sat_q[i] || (scaled[i][25:15] > 11'(MAX8))) byte_c[i] = MAX8;
      else byte_c[i] = scaled[i][22:15];
    end
    amul = 24'(den_q) * 24'(MAX8) + 24'(FIX15_HALF);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (emit) out_valid_q <= 1'b1;
      else if (!stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      den_q <= pix_i.alpha;
      for (int i = 0; i < NCHAN; i++) begin
        // quotient at or above 2^17 saturates; otherwise the high part
        // starts below the divisor
        sat_q[i] <= ({2'b00, num[i][30:17]} >= pix_i.alpha);
        rem_q[i] <= {2'b00, num[i][30:17]};
        nq_q[i]  <= num[i][16:0];
      end
    end else if (step) begin
      for (int i = 0; i < NCHAN; i++) begin
        rem_q[i] <= ge[i] ? 16'(trial[i] - {1'b0, den_q}) : trial[i][15:0];
        nq_q[i]  <= {nq_q[i][QBITS-2:0], ge[i]};
      end
    end
    if (emit) begin
      for (int i = 0; i < NCHAN; i++) byte_q[i] <= byte_c[i];
      alpha_out_q <= amul[23:16];
    end
  end

  assign valid_o     = out_valid_q;
  assign red_out_o   = byte_q[0];
  assign green_out_o = byte_q[1];
  assign blue_out_o  = byte_q[2];
  assign alpha_out_o = alpha_out_q;

`ifndef SYNTHESIS
  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIV && cnt_q == LAST_STEP) |=> (state_q == B_DONE))
    else $error("divider did not finish after last step");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for layer_over_composite_to_rgb8. Layer items are fed
// bottom first through the valid/stall input channel. A behavioral
// compositor follows each accepted item and queues the 8-bit pixel that a
// top layer must produce. Every pixel taken from the output channel is
// checked against the oldest queued pixel. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import locr8_pkg::*;

  // One layer of one pixel, as driven on the input ports.
  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
    logic [15:0] opacity;
    logic        is_first;
    logic        is_last;
  } layer_t;

  // One converted pixel, as seen on the output ports.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba8_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        valid_i       = 1'b0;
  logic [15:0] red_i         = '0;
  logic [15:0] green_i       = '0;
  logic [15:0] blue_i        = '0;
  logic [15:0] alpha_i       = '0;
  logic [15:0] opacity_i     = '0;
  logic        first_layer_i = 1'b0;
  logic        last_layer_i  = 1'b0;
  logic        stall_i       = 1'b0;
  logic        stall_o;
  logic        valid_o;
  logic [7:0]  red_out_o;
  logic [7:0]  green_out_o;
  logic [7:0]  blue_out_o;
  logic [7:0]  alpha_out_o;

  // Behavioral copy of the premultiplied accumulator (zero after reset).
  pix_t   blend_acc = '0;
  // Pixels the block still owes us, oldest first.
  rgba8_t pixel_q[$];
  int     mismatches = 0;
  // Random idling on both channels; cleared for a stretch of full rate.
  bit     gaps_on = 1'b1;
  int     stall_hold = 0;

  layer_over_composite_to_rgb8 dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .alpha_i      (alpha_i),
    .opacity_i    (opacity_i),
    .first_layer_i(first_layer_i),
    .last_layer_i (last_layer_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .alpha_out_o  (alpha_out_o)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #4_000_000;
    $display("** layer_over_composite_to_rgb8: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Compositor arithmetic
  // --------------------------------------------------------------------------

  // (top*op + acc*(one - p)) >> 15, saturated to 16 bits.
  function automatic logic [15:0] over_chan(logic [15:0] top, logic [15:0] op,
                                            logic [15:0] acc, logic [31:0] minus);
    logic [63:0] s;
    s = (64'(top) * 64'(op) + 64'(acc) * 64'(minus)) >> 15;
    return (s > 64'(MAX16)) ? MAX16 : s[15:0];
  endfunction

  // Un-premultiply with rounding, then scale to a byte with rounding.
  // A zero alpha gives a zero colour.
  function automatic logic [7:0] unpremul_byte(logic [15:0] c, logic [15:0] a);
    logic [63:0] u;
    logic [63:0] v;
    if (a == '0) return '0;
    u = ((64'(c) << 15) + 64'(a / 2)) / 64'(a);
    v = (u * 64'(MAX8) + 64'(FIX15_HALF)) >> 15;
    return (v > 64'(MAX8)) ? MAX8 : v[7:0];
  endfunction

  // Fold one accepted layer into the accumulator; a top layer queues a pixel.
  task automatic blend_layer(input layer_t l);
    logic [31:0] p;
    logic [31:0] minus;
    logic [31:0] na;
    logic [31:0] a_scaled;
    rgba8_t      px;
    if (l.is_first) begin
      // bottom layer loads as is, opacity ignored
      blend_acc = '{red: l.red, green: l.green, blue: l.blue, alpha: l.alpha};
    end else begin
      p = (32'(l.alpha) * 32'(l.opacity)) >> 15;
      if (p > 32'(UNITY_FX)) p = 32'(UNITY_FX);
      minus = 32'(UNITY_FX) - p;
      blend_acc.red   = over_chan(l.red,   l.opacity, blend_acc.red,   minus);
      blend_acc.green = over_chan(l.green, l.opacity, blend_acc.green, minus);
      blend_acc.blue  = over_chan(l.blue,  l.opacity, blend_acc.blue,  minus);
      na = p + ((32'(blend_acc.alpha) * minus) >> 15);
      blend_acc.alpha = (na > 32'(UNITY_FX)) ? UNITY_FX : na[15:0];
    end
    if (l.is_last) begin
      px.red   = unpremul_byte(blend_acc.red,   blend_acc.alpha);
      px.green = unpremul_byte(blend_acc.green, blend_acc.alpha);
      px.blue  = unpremul_byte(blend_acc.blue,  blend_acc.alpha);
      a_scaled = 32'(blend_acc.alpha) * 32'(MAX8) + 32'(FIX15_HALF);
      px.alpha = a_scaled[23:16];
      pixel_q.insert(pixel_q.size(), px);
    end
  endtask

  // --------------------------------------------------------------------------
  // Input side: called at a falling edge, returns at a falling edge with
  // valid_i still high so back-to-back items need no extra assignment.
  // --------------------------------------------------------------------------
  task automatic send_layer(input layer_t l);
    if (gaps_on) begin
      while ($urandom_range(99) < 30) begin
        valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    valid_i       <= 1'b1;
    red_i         <= l.red;
    green_i       <= l.green;
    blue_i        <= l.blue;
    alpha_i       <= l.alpha;
    opacity_i     <= l.opacity;
    first_layer_i <= l.is_first;
    last_layer_i  <= l.is_last;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    blend_layer(l);
    @(negedge clk_i);
  endtask

  // Drop valid and hold off until every owed pixel has come out.
  task automatic wait_drained();
    valid_i <= 1'b0;
    do @(negedge clk_i); while (pixel_q.size() != 0);
  endtask

  function automatic layer_t mk_layer(int r, int g, int b, int a, int op,
                                      bit is_first, bit is_last);
    layer_t l;
    l.red      = 16'(r);
    l.green    = 16'(g);
    l.blue     = 16'(b);
    l.alpha    = 16'(a);
    l.opacity  = 16'(op);
    l.is_first = is_first;
    l.is_last  = is_last;
    return l;
  endfunction

  // fix15 value biased toward the edges of 0..one
  function automatic logic [15:0] fix15_val();
    case ($urandom_range(9))
      0:       return '0;
      1:       return UNITY_FX;
      2:       return UNITY_FX - 16'd1;
      3:       return 16'd1;
      4:       return 16'($urandom_range(0, 255));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  // Mostly proper premultiplied colour (colour <= alpha), sometimes not.
  function automatic layer_t rand_layer();
    layer_t l;
    l.alpha   = fix15_val();
    l.opacity = fix15_val();
    if ($urandom_range(4) != 0) begin
      l.red   = 16'($urandom_range(0, l.alpha));
      l.green = 16'($urandom_range(0, l.alpha));
      l.blue  = 16'($urandom_range(0, l.alpha));
    end else begin
      l.red   = fix15_val();
      l.green = fix15_val();
      l.blue  = fix15_val();
    end
    l.is_first = 1'b0;
    l.is_last  = 1'b0;
    return l;
  endfunction

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------

  // Random stall, with a rare long hold that backs up the pixel queue.
  always @(negedge clk_i) begin
    if (stall_hold != 0) begin
      stall_hold--;
      stall_i <= 1'b1;
    end else if (gaps_on && $urandom_range(199) == 0) begin
      stall_hold = $urandom_range(20, 60);
      stall_i <= 1'b1;
    end else begin
      stall_i <= gaps_on && ($urandom_range(99) < 30);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : take_pixel
    rgba8_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (pixel_q.size() == 0) begin
        $error("pixel out with none expected: %0d %0d %0d %0d",
               red_out_o, green_out_o, blue_out_o, alpha_out_o);
        mismatches++;
      end else begin
        want = pixel_q.pop_front();
        check_field("red_out",   want.red,   red_out_o);
        check_field("green_out", want.green, green_out_o);
        check_field("blue_out",  want.blue,  blue_out_o);
        check_field("alpha_out", want.alpha, alpha_out_o);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Right after reset, a top layer with no bottom layer blends over zero.
  task automatic test_no_first_layer();
    send_layer(mk_layer(8192, 8192, 8192, 16384, 32768, 1'b0, 1'b1));
  endtask

  // First and last on one item: the layer is converted as loaded.
  task automatic test_single_layer();
    send_layer(mk_layer(32768, 32768, 32768, 32768, 0, 1'b1, 1'b1));
    send_layer(mk_layer(0, 0, 0, 0, 32768, 1'b1, 1'b1));
    // colour far above alpha saturates the byte
    send_layer(mk_layer(32768, 1, 0, 1, 12345, 1'b1, 1'b1));
    send_layer(mk_layer(16384, 8191, 32767, 16384, 1, 1'b1, 1'b1));
  endtask

  // Accumulated alpha zero: colours forced to zero.
  task automatic test_zero_alpha();
    send_layer(mk_layer(32768, 32768, 32768, 0, 32768, 1'b1, 1'b0));
    send_layer(mk_layer(32768, 32768, 32768, 32768, 0, 1'b0, 1'b1));
  endtask

  // Full cover (alpha*opacity exactly one) then a fully transparent layer.
  task automatic test_opacity_extremes();
    send_layer(mk_layer(8000, 4000, 2000, 16384, 7, 1'b1, 1'b0));
    send_layer(mk_layer(30000, 20000, 10000, 32768, 32768, 1'b0, 1'b0));
    send_layer(mk_layer(32768, 32768, 32768, 32768, 0, 1'b0, 1'b1));
  endtask

  // Colour sums past 16 bits clip at 65535 and stay clipped.
  task automatic test_colour_saturation();
    send_layer(mk_layer(32768, 32768, 32768, 32768, 0, 1'b1, 1'b0));
    send_layer(mk_layer(32768, 32768, 32768, 0, 32768, 1'b0, 1'b0));
    send_layer(mk_layer(32768, 30000, 32768, 0, 32768, 1'b0, 1'b1));
  endtask

  // After a pixel goes out the accumulator carries into a headless item.
  task automatic test_keep_after_emit();
    send_layer(mk_layer(20000, 10000, 5000, 24000, 0, 1'b1, 1'b1));
    send_layer(mk_layer(1000, 2000, 3000, 4000, 20000, 1'b0, 1'b1));
  endtask

  // Sender holds off until the block is empty, then resumes.
  task automatic test_pause_until_drained();
    send_layer(mk_layer(12000, 6000, 3000, 16000, 0, 1'b1, 1'b0));
    send_layer(mk_layer(5000, 5000, 5000, 9000, 30000, 1'b0, 1'b1));
    wait_drained();
    send_layer(mk_layer(100, 200, 300, 400, 0, 1'b1, 1'b0));
    send_layer(mk_layer(32767, 0, 16383, 32767, 32767, 1'b0, 1'b1));
  endtask

  // Mostly proper pixels of 1..4 layers (a few deep ones), some noise with
  // random first/last flags, and one stretch without any idling.
  task automatic test_random_pixels();
    int     sent;
    int     n;
    bit     noise;
    layer_t l;
    sent = 0;
    while (sent < 1850) begin
      gaps_on = !(sent >= 600 && sent < 900);
      noise = ($urandom_range(9) == 0);
      n = ($urandom_range(7) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
      for (int k = 0; k < n; k++) begin
        l = rand_layer();
        if (noise) begin
          l.is_first = ($urandom_range(1) != 0);
          l.is_last  = ($urandom_range(3) == 0);
        end else begin
          l.is_first = (k == 0);
          l.is_last  = (k == n - 1);
        end
        send_layer(l);
      end
      sent += n;
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_no_first_layer();
    test_single_layer();
    test_zero_alpha();
    test_opacity_extremes();
    test_colour_saturation();
    test_keep_after_emit();
    test_pause_until_drained();
    test_random_pixels();

    // drain, then give the back end time to show any stray pixel
    wait_drained();
    repeat (50) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("** layer_over_composite_to_rgb8: PASSED **");
    end else begin
      $display("** layer_over_composite_to_rgb8: FAILED **");
    end
    $finish;
  end

endmodule
